@@ rtl/core/pollard_rho_factorizer_core_assert.svh @@
// Assertion macros for the core RTL.
// Needs nothing; files take it in by include ahead of their module.
`ifndef POLLARD_RHO_FACTORIZER_CORE_ASSERT_SVH
`define POLLARD_RHO_FACTORIZER_CORE_ASSERT_SVH

// same-cycle implication
`define PRF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define PRF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ rtl/core/prf_pkg.sv @@
// Package for the Pollard rho factorizer: widths, limits, codes, state types.
// Depends on nothing.
package prf_pkg;

	localparam int VALUE_WIDTH        = 64;
	localparam int FACTOR_WIDTH       = 32;
	localparam int COMPOSITE_WIDTH    = 64;
	localparam int FACTOR_FIELD_WIDTH = 32;
	localparam int STATUS_WIDTH       = 2;
	localparam int ROUND_LIMIT        = 1048576;
	localparam int ROUND_CNT_WIDTH    = 21;

	typedef enum logic [STATUS_WIDTH-1:0] {
		STAT_FACTORED = 2'd0,
		STAT_FAILED   = 2'd1,
		STAT_OVERFLOW = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_MUL_WAIT,
		S_GCD,
		S_GCD_WAIT,
		S_DIV,
		S_DIV_WAIT,
		S_DONE
	} core_state_t;

	typedef enum logic [1:0] {
		G_IDLE,
		G_REDUCE,
		G_RESTORE
	} gcd_state_t;

endpackage

@@ rtl/core/prf_req_if.sv @@
// Request channel: one composite per request.
// Depends on prf_pkg.
interface prf_req_if;
	import prf_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [COMPOSITE_WIDTH-1:0] composite;

	modport source (output valid, output composite, input ready);
	modport sink   (input valid, input composite, output ready);
endinterface

@@ rtl/core/prf_rsp_if.sv @@
// Result channel: two factors and a status per request.
// Depends on prf_pkg.
interface prf_rsp_if;
	import prf_pkg::*;

	logic                          valid;
	logic                          ready;
	logic [FACTOR_FIELD_WIDTH-1:0] smaller_factor;
	logic [FACTOR_FIELD_WIDTH-1:0] larger_factor;
	logic [STATUS_WIDTH-1:0]       status;

	modport source (output valid, output smaller_factor, output larger_factor,
		output status, input ready);
	modport sink   (input valid, input smaller_factor, input larger_factor,
		input status, output ready);
endinterface

@@ rtl/core/prf_mulmod.sv @@
// Bit-serial modular multiplier: square of op mod modulus, MSB first.
// Each multiplier bit is a double, then a conditional add. Uses prf_pkg.
module prf_mulmod #(
	parameter int VALUE_WIDTH = prf_pkg::VALUE_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] op,
	input  logic [VALUE_WIDTH-1:0] modulus,
	output logic                   done,
	output logic [VALUE_WIDTH-1:0] prod
);
	import prf_pkg::*;

	localparam int CW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

	logic [VALUE_WIDTH-1:0] r_q, a_q, b_q, n_q;
	logic [CW-1:0]          cnt_q;
	logic                   phase_q, busy_q, done_q;
	logic [VALUE_WIDTH-1:0] addend, r_nx;
	logic [VALUE_WIDTH:0]   sum;

	// (r + addend) mod n, both below n
	always_comb begin
		addend = phase_q ? a_q : r_q;
		sum    = {1'b0, r_q} + {1'b0, addend};
		if (sum >= {1'b0, n_q}) begin
			r_nx = VALUE_WIDTH'(sum - {1'b0, n_q});
		end else begin
			r_nx = sum[VALUE_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			phase_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				phase_q <= 1'b0;
				cnt_q   <= CW'(VALUE_WIDTH - 1);
			end else if (busy_q) begin
				phase_q <= ~phase_q;
				if (phase_q) begin
					if (cnt_q == '0) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= '0;
			a_q <= op;
			b_q <= op;
			n_q <= modulus;
		end else if (busy_q) begin
			if (!phase_q || b_q[VALUE_WIDTH-1]) begin
				r_q <= r_nx;
			end
			if (phase_q) begin
				b_q <= {b_q[VALUE_WIDTH-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign prod = r_q;
endmodule

@@ rtl/core/prf_gcd.sv @@
// Binary gcd unit: one shift or one subtract per cycle, then the common
// power of two is shifted back one bit per cycle. Uses prf_pkg.
module prf_gcd #(
	parameter int VALUE_WIDTH = prf_pkg::VALUE_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] a_in,
	input  logic [VALUE_WIDTH-1:0] b_in,
	output logic                   done,
	output logic [VALUE_WIDTH-1:0] gcd_res
);
	import prf_pkg::*;

	localparam int KW = $clog2(VALUE_WIDTH + 1);

	gcd_state_t             state_q, state_nx;
	logic [VALUE_WIDTH-1:0] ga_q, gb_q;
	logic [KW-1:0]          gk_q;
	logic                   done_q, done_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= G_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			done_q  <= done_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		done_nx  = 1'b0;
		unique case (state_q)
			G_IDLE: begin
				if (start) state_nx = G_REDUCE;
			end
			G_REDUCE: begin
				if (ga_q == '0) state_nx = G_RESTORE;
			end
			G_RESTORE: begin
				if (gk_q == '0) begin
					state_nx = G_IDLE;
					done_nx  = 1'b1;
				end
			end
			default: state_nx = G_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			G_IDLE: begin
				if (start) begin
					ga_q <= a_in;
					gb_q <= b_in;
					gk_q <= '0;
				end
			end
			G_REDUCE: begin
				if (ga_q != '0) begin
					if (!ga_q[0] && !gb_q[0]) begin
						ga_q <= ga_q >> 1;
						gb_q <= gb_q >> 1;
						gk_q <= gk_q + 1'b1;
					end else if (!ga_q[0]) begin
						ga_q <= ga_q >> 1;
					end else if (!gb_q[0]) begin
						gb_q <= gb_q >> 1;
					end else if (ga_q >= gb_q) begin
						ga_q <= ga_q - gb_q;
					end else begin
						gb_q <= gb_q - ga_q;
					end
				end
			end
			G_RESTORE: begin
				if (gk_q != '0) begin
					gb_q <= gb_q << 1;
					gk_q <= gk_q - 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign done    = done_q;
	assign gcd_res = gb_q;
endmodule

@@ rtl/core/prf_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Uses prf_pkg for the default width.
module prf_div #(
	parameter int VALUE_WIDTH = prf_pkg::VALUE_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] dividend,
	input  logic [VALUE_WIDTH-1:0] divisor,
	output logic                   done,
	output logic [VALUE_WIDTH-1:0] quot
);
	import prf_pkg::*;

	localparam int CW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

	logic [VALUE_WIDTH-1:0] rem_q, q_q, d_q;
	logic [CW-1:0]          cnt_q;
	logic                   busy_q, done_q;
	logic [VALUE_WIDTH:0]   trial;

	assign trial = {rem_q, q_q[VALUE_WIDTH-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(VALUE_WIDTH - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			q_q   <= dividend;
			d_q   <= divisor;
		end else if (busy_q) begin
			if (trial >= {1'b0, d_q}) begin
				rem_q <= VALUE_WIDTH'(trial - {1'b0, d_q});
				q_q   <= {q_q[VALUE_WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= trial[VALUE_WIDTH-1:0];
				q_q   <= {q_q[VALUE_WIDTH-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = q_q;
endmodule

@@ rtl/core/pollard_rho_factorizer_core.sv @@
// Pollard rho factorizer core. One request carries a composite n; the low
// VALUE_WIDTH bits are used. The core walks x -> x*x+1 mod n (tortoise once,
// hare twice per round, both from 2), takes gcd(|x-y|, n) after each round
// and stops at the first gcd that is not 1, or fails after ROUND_LIMIT
// rounds. One result per request: smaller factor, larger factor, status
// (0 factored, 1 no factor or n below 2, 2 factor wider than FACTOR_WIDTH).
// Each round runs three squarings in the bit-serial multiplier and one binary
// gcd; a factor that is found is split off by one final division. The
// number of rounds is near sqrt(smallest prime factor), e.g. about 65536
// rounds for two 32-bit primes. One request is in work at a time; a new
// request is taken once the previous result has moved to the output register.
// Depends on prf_pkg, prf_req_if, prf_rsp_if, prf_mulmod, prf_gcd, prf_div.
`include "pollard_rho_factorizer_core_assert.svh"

module pollard_rho_factorizer_core #(
	parameter int VALUE_WIDTH  = prf_pkg::VALUE_WIDTH,
	parameter int FACTOR_WIDTH = prf_pkg::FACTOR_WIDTH
) (
	input logic      clk,
	input logic      arst_n,
	prf_req_if.sink  request,
	prf_rsp_if.source result
);
	import prf_pkg::*;

	localparam int WW = VALUE_WIDTH + FACTOR_WIDTH;

	core_state_t state_q, state_nx;

	logic [VALUE_WIDTH-1:0]     n_q, x_q, y_q, d_q;
	logic [1:0]                 sel_q;        // 0 tortoise, 1..2 hare steps
	logic [ROUND_CNT_WIDTH-1:0] round_q, round_nx;

	// final answer, waiting for the output register
	logic [FACTOR_FIELD_WIDTH-1:0] fin_lo_q, fin_hi_q;
	status_t                       fin_stat_q;

	// output register
	logic                          res_valid_q;
	logic [FACTOR_FIELD_WIDTH-1:0] res_lo_q, res_hi_q;
	status_t                       res_stat_q;

	logic [VALUE_WIDTH-1:0] n_in, mul_op, mul_prod, step_val, diff;
	logic [VALUE_WIDTH-1:0] gcd_res, quot, lo, hi;
	logic [VALUE_WIDTH:0]   step_sum;
	logic [WW-1:0]          lo_wide, hi_wide;
	logic                   mul_start, mul_done, gcd_start, gcd_done;
	logic                   div_start, div_done, accept, out_free;

	assign n_in     = request.composite[VALUE_WIDTH-1:0];
	assign accept   = request.valid && request.ready;
	assign out_free = !res_valid_q || result.ready;
	assign round_nx = round_q + 1'b1;

	assign mul_op = (sel_q == 2'd0) ? x_q : y_q;

	// square + 1, wrapped once at n
	assign step_sum = {1'b0, mul_prod} + 1'b1;
	assign step_val = (step_sum == {1'b0, n_q}) ? '0 : step_sum[VALUE_WIDTH-1:0];

	assign diff = (x_q > y_q) ? (x_q - y_q) : (y_q - x_q);

	// order the pair and check the wider one against the factor width
	assign lo      = (d_q > quot) ? quot : d_q;
	assign hi      = (d_q > quot) ? d_q : quot;
	assign lo_wide = WW'(lo);
	assign hi_wide = WW'(hi);

	prf_mulmod #(.VALUE_WIDTH(VALUE_WIDTH)) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.op      (mul_op),
		.modulus (n_q),
		.done    (mul_done),
		.prod    (mul_prod)
	);

	prf_gcd #(.VALUE_WIDTH(VALUE_WIDTH)) u_gcd (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (gcd_start),
		.a_in    (diff),
		.b_in    (n_q),
		.done    (gcd_done),
		.gcd_res (gcd_res)
	);

	prf_div #(.VALUE_WIDTH(VALUE_WIDTH)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (n_q),
		.divisor  (d_q),
		.done     (div_done),
		.quot     (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx  = state_q;
		mul_start = 1'b0;
		gcd_start = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (request.valid) begin
					state_nx = (n_in < VALUE_WIDTH'(2)) ? S_DONE : S_MUL;
				end
			end
			S_MUL: begin
				mul_start = 1'b1;
				state_nx  = S_MUL_WAIT;
			end
			S_MUL_WAIT: begin
				if (mul_done) state_nx = (sel_q == 2'd2) ? S_GCD : S_MUL;
			end
			S_GCD: begin
				gcd_start = 1'b1;
				state_nx  = S_GCD_WAIT;
			end
			S_GCD_WAIT: begin
				if (gcd_done) begin
					if (gcd_res == VALUE_WIDTH'(1)) begin
						state_nx = (round_nx == ROUND_CNT_WIDTH'(ROUND_LIMIT)) ? S_DONE : S_MUL;
					end else if (gcd_res == n_q) begin
						state_nx = S_DONE;
					end else begin
						state_nx = S_DIV;
					end
				end
			end
			S_DIV: begin
				div_start = 1'b1;
				state_nx  = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (div_done) state_nx = S_DONE;
			end
			S_DONE: begin
				if (out_free) state_nx = S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// walk state and final answer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q   <= '0;
			round_q <= '0;
		end else begin
			if (state_q == S_IDLE && accept) begin
				sel_q   <= '0;
				round_q <= '0;
			end else if (state_q == S_MUL_WAIT && mul_done) begin
				sel_q <= (sel_q == 2'd2) ? 2'd0 : sel_q + 1'b1;
			end else if (state_q == S_GCD_WAIT && gcd_done) begin
				round_q <= round_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					n_q        <= n_in;
					x_q        <= (n_in == VALUE_WIDTH'(2)) ? '0 : VALUE_WIDTH'(2);
					y_q        <= (n_in == VALUE_WIDTH'(2)) ? '0 : VALUE_WIDTH'(2);
					fin_lo_q   <= '0;
					fin_hi_q   <= '0;
					fin_stat_q <= STAT_FAILED;
				end
			end
			S_MUL_WAIT: begin
				if (mul_done) begin
					if (sel_q == 2'd0) begin
						x_q <= step_val;
					end else begin
						y_q <= step_val;
					end
				end
			end
			S_GCD_WAIT: begin
				if (gcd_done) d_q <= gcd_res;
			end
			S_DIV_WAIT: begin
				if (div_done) begin
					if (hi_wide[WW-1:FACTOR_WIDTH] != '0) begin
						fin_stat_q <= STAT_OVERFLOW;
					end else begin
						fin_lo_q   <= FACTOR_FIELD_WIDTH'(lo_wide[FACTOR_WIDTH-1:0]);
						fin_hi_q   <= FACTOR_FIELD_WIDTH'(hi_wide[FACTOR_WIDTH-1:0]);
						fin_stat_q <= STAT_FACTORED;
					end
				end
			end
			default: ;
		endcase
	end

	// output register parts the result channel from the walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			res_lo_q   <= fin_lo_q;
			res_hi_q   <= fin_hi_q;
			res_stat_q <= fin_stat_q;
		end
	end

	assign request.ready         = (state_q == S_IDLE);
	assign result.valid          = res_valid_q;
	assign result.smaller_factor = res_lo_q;
	assign result.larger_factor  = res_hi_q;
	assign result.status         = res_stat_q;

	`PRF_ASSERT_IMP(a_fail_zero, clk, arst_n,
		res_valid_q && res_stat_q != STAT_FACTORED, res_lo_q == '0 && res_hi_q == '0)
	`PRF_ASSERT_IMP(a_ordered, clk, arst_n,
		res_valid_q && res_stat_q == STAT_FACTORED, res_lo_q <= res_hi_q)
	`PRF_ASSERT_IMP(a_mul_done_when_waiting, clk, arst_n, mul_done, state_q == S_MUL_WAIT)
	`PRF_ASSERT_IMP(a_gcd_done_when_waiting, clk, arst_n, gcd_done, state_q == S_GCD_WAIT)
	`PRF_ASSERT_NXT(a_start_to_wait, clk, arst_n, mul_start, state_q == S_MUL_WAIT)
endmodule
